@@ design/quvi_pkg.sv @@
`timescale 1ns / 1ps

package quvi_pkg;

  // Coordinates are fixed at 24 bits (Q3.20 at the default fraction width).
  localparam int COORD_W = 24;
  localparam int QUAD_CORNERS = 4;
  localparam int AXES = 2;

  // Largest half-texel step that the state register can hold.
  localparam logic [COORD_W-1:0] HALF_MAX = 24'h7FFFFF;

  // Configuration register indexes.
  localparam logic [1:0] REG_TEX_WIDTH  = 2'd0;
  localparam logic [1:0] REG_TEX_HEIGHT = 2'd1;

  // Status of one half-texel divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ design/quvi_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. A zero divisor yields zero.
module quvi_div #(
  parameter int DW = 21,
  parameter int TW = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DW-1:0]        dividend,
  input  logic [TW-1:0]        divisor,
  output quvi_pkg::div_stat_t  stat,
  output logic [DW-1:0]        quot
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [TW:0]   rem;
  logic [DW-1:0] shreg;
  logic [TW-1:0] dsr;

  logic [TW:0]   rem_sh;
  logic          ge;
  logic [TW:0]   rem_next;
  logic [DW-1:0] shreg_next;

  always_comb begin
    rem_sh     = {rem[TW-1:0], shreg[DW-1]};
    ge         = rem_sh >= {1'b0, dsr};
    rem_next   = ge ? (rem_sh - {1'b0, dsr}) : rem_sh;
    shreg_next = {shreg[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shreg <= dividend;
      dsr   <= divisor;
    end else if (busy) begin
      rem   <= rem_next;
      shreg <= shreg_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quot      = (dsr == '0) ? '0 : shreg;

endmodule

@@ design/quad_uv_half_texel_inset.sv @@
`timescale 1ns / 1ps

// Half-texel inset of one textured quad per item. Each item carries the four u
// and four v corner coordinates of a quad (signed, UV_FRAC_BITS fraction bits)
// in s_tdata, the all-edges mode flag in s_tuser and the batch-end mark in
// s_tlast. For each axis the block finds the minimum and maximum corner; when
// the span exceeds two half-texel steps, corners at the minimum move up and
// corners at the maximum move down by one step. In seam mode only extremes
// strictly inside 0..1 that sit within 0.01 texel of a texel boundary move. A
// texture size of zero on either axis passes quads through untouched, which is
// the state after reset. The datapath is a four-stage pipeline (min/max, span
// compare and seam multiply, seam distance test, edge update) that takes one
// quad every cycle while the output is not stalled and no divider is busy;
// m_tvalid rises once the quad has passed through stages A, B, C and D.
// Writing a size register starts a restoring divider for that axis's
// half-texel step, one quotient bit per cycle; s_tready stays low while
// either divider is busy.
module quad_uv_half_texel_inset #(
  parameter int UV_FRAC_BITS = 20,
  parameter int TEX_DIM_BITS = 14
) (
  input  logic                    clk,
  input  logic                    rst,

  input  logic                    s_tvalid,
  output logic                    s_tready,
  // Fields from bit 0 up: u_a, u_b, u_c, u_d, v_a, v_b, v_c, v_d (24 bits each).
  input  logic [191:0]            s_tdata,
  // Fields from bit 0 up: all_edges.
  input  logic                    s_tuser,
  input  logic                    s_tlast,

  output logic                    m_tvalid,
  input  logic                    m_tready,
  // Fields from bit 0 up: new_u_a, new_u_b, new_u_c, new_u_d,
  // new_v_a, new_v_b, new_v_c, new_v_d (24 bits each).
  output logic [191:0]            m_tdata,
  output logic                    m_tlast,

  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [TEX_DIM_BITS-1:0] cfg_data
);

  localparam int CW  = quvi_pkg::COORD_W;
  localparam int NC  = quvi_pkg::QUAD_CORNERS;
  localparam int NA  = quvi_pkg::AXES;
  localparam int FB  = UV_FRAC_BITS;
  localparam int TW  = TEX_DIM_BITS;
  localparam int DW  = ((FB > TW) ? FB : TW) + 1;
  localparam int PW  = CW + TW;

  localparam longint ONE_L = 64'd1 << FB;
  localparam longint TOL_L = (ONE_L + 50) / 100;
  localparam logic [FB-1:0] SEAM_LO = FB'(TOL_L);
  localparam logic [FB-1:0] SEAM_HI = FB'(ONE_L - TOL_L);
  localparam logic [32:0]   ONE_33  = 33'(ONE_L);
  localparam logic [DW-1:0] HALF_ONE = DW'(64'd1 << (FB - 1));

  // ---------------------------------------------------------------------------
  // Configuration and half-texel steps
  // ---------------------------------------------------------------------------
  logic [TW-1:0] tex_width;
  logic [TW-1:0] tex_height;
  logic [CW-1:0] half_u;
  logic [CW-1:0] half_v;

  logic                start_u;
  logic                start_v;
  logic [DW-1:0]       dividend;
  quvi_pkg::div_stat_t stat_u;
  quvi_pkg::div_stat_t stat_v;
  logic [DW-1:0]       quot_u;
  logic [DW-1:0]       quot_v;

  always_comb begin
    start_u = 1'b0;
    start_v = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        quvi_pkg::REG_TEX_WIDTH:  start_u = 1'b1;
        quvi_pkg::REG_TEX_HEIGHT: start_v = 1'b1;
        default: ;
      endcase
    end
  end

  // Rounded step numerator: half a unit plus half the size.
  assign dividend = HALF_ONE + DW'(cfg_data >> 1);

  quvi_div #(.DW(DW), .TW(TW)) u_div_u (
    .clk      (clk),
    .rst      (rst),
    .start    (start_u),
    .dividend (dividend),
    .divisor  (cfg_data),
    .stat     (stat_u),
    .quot     (quot_u)
  );

  quvi_div #(.DW(DW), .TW(TW)) u_div_v (
    .clk      (clk),
    .rst      (rst),
    .start    (start_v),
    .dividend (dividend),
    .divisor  (cfg_data),
    .stat     (stat_v),
    .quot     (quot_v)
  );

  function automatic logic [CW-1:0] sat_half(input logic [DW-1:0] q);
    logic [32:0] q33;
    q33 = 33'(q);
    return (q33 > 33'(quvi_pkg::HALF_MAX)) ? quvi_pkg::HALF_MAX : q33[CW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= '0;
      tex_height <= '0;
      half_u     <= '0;
      half_v     <= '0;
    end else begin
      if (start_u) tex_width <= cfg_data;
      if (start_v) tex_height <= cfg_data;
      if (stat_u.done) half_u <= sat_half(quot_u);
      if (stat_v.done) half_v <= sat_half(quot_v);
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake: each stage loads when it is empty or its successor
  // takes its item.
  // ---------------------------------------------------------------------------
  logic a_valid, b_valid, c_valid, o_valid;
  logic a_ready, b_ready, c_ready, o_ready;
  logic s_fire;

  assign o_ready  = !o_valid || m_tready;
  assign c_ready  = !c_valid || o_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign s_tready = a_ready && !stat_u.busy && !stat_v.busy;
  assign s_fire   = s_tvalid && s_tready;

  logic [TW-1:0] size_ax [NA];
  logic [CW-1:0] half_ax [NA];
  logic          size_ok;

  assign size_ax[0] = tex_width;
  assign size_ax[1] = tex_height;
  assign half_ax[0] = half_u;
  assign half_ax[1] = half_v;
  assign size_ok    = (tex_width != '0) && (tex_height != '0);

  // ---------------------------------------------------------------------------
  // Stage A: minimum and maximum of each axis.
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] in_c [NA*NC];
  logic signed [CW-1:0] lo_ax [NA];
  logic signed [CW-1:0] hi_ax [NA];

  always_comb begin
    logic signed [CW-1:0] l0, l1, h0, h1;
    for (int k = 0; k < NA * NC; k++) begin
      in_c[k] = s_tdata[k*CW +: CW];
    end
    for (int ax = 0; ax < NA; ax++) begin
      l0 = (in_c[ax*NC+1] < in_c[ax*NC])   ? in_c[ax*NC+1] : in_c[ax*NC];
      l1 = (in_c[ax*NC+3] < in_c[ax*NC+2]) ? in_c[ax*NC+3] : in_c[ax*NC+2];
      h0 = (in_c[ax*NC+1] > in_c[ax*NC])   ? in_c[ax*NC+1] : in_c[ax*NC];
      h1 = (in_c[ax*NC+3] > in_c[ax*NC+2]) ? in_c[ax*NC+3] : in_c[ax*NC+2];
      lo_ax[ax] = (l1 < l0) ? l1 : l0;
      hi_ax[ax] = (h1 > h0) ? h1 : h0;
    end
  end

  logic signed [CW-1:0] a_c  [NA*NC];
  logic signed [CW-1:0] a_lo [NA];
  logic signed [CW-1:0] a_hi [NA];
  logic                 a_all;
  logic                 a_last;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (a_ready) a_valid <= s_fire;
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      a_c    <= in_c;
      a_lo   <= lo_ax;
      a_hi   <= hi_ax;
      a_all  <= s_tuser;
      a_last <= s_tlast;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: span test, seam products and the open 0..1 range test.
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] b_c  [NA*NC];
  logic signed [CW-1:0] b_lo [NA];
  logic signed [CW-1:0] b_hi [NA];
  logic                 b_all;
  logic                 b_last;
  logic                 b_wide [NA];
  logic [PW-1:0]        b_plo  [NA];
  logic [PW-1:0]        b_phi  [NA];
  logic                 b_rlo  [NA];
  logic                 b_rhi  [NA];

  function automatic logic in_unit(input logic signed [CW-1:0] c);
    logic [32:0] c33;
    c33 = {{(33 - CW){c[CW-1]}}, c};
    return !c[CW-1] && (c != '0) && (c33 < ONE_33);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (b_ready) b_valid <= a_valid;
  end

  always_ff @(posedge clk) begin
    logic [CW:0] span;
    if (a_valid && b_ready) begin
      b_c    <= a_c;
      b_lo   <= a_lo;
      b_hi   <= a_hi;
      b_all  <= a_all;
      b_last <= a_last;
      for (int ax = 0; ax < NA; ax++) begin
        span       = {a_hi[ax][CW-1], a_hi[ax]} - {a_lo[ax][CW-1], a_lo[ax]};
        b_wide[ax] <= span > {half_ax[ax], 1'b0};
        b_plo[ax]  <= PW'(a_lo[ax][CW-1:0]) * PW'(size_ax[ax]);
        b_phi[ax]  <= PW'(a_hi[ax][CW-1:0]) * PW'(size_ax[ax]);
        b_rlo[ax]  <= in_unit(a_lo[ax]);
        b_rhi[ax]  <= in_unit(a_hi[ax]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: decide which extremes move.
  // ---------------------------------------------------------------------------
  function automatic logic near_int(input logic [PW-1:0] p);
    logic [FB-1:0] frac;
    frac = p[FB-1:0];
    return (frac < SEAM_LO) || (frac > SEAM_HI);
  endfunction

  logic signed [CW-1:0] c_c  [NA*NC];
  logic signed [CW-1:0] c_lo [NA];
  logic signed [CW-1:0] c_hi [NA];
  logic                 c_last;
  logic                 c_mlo [NA];
  logic                 c_mhi [NA];

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else if (c_ready) c_valid <= b_valid;
  end

  always_ff @(posedge clk) begin
    if (b_valid && c_ready) begin
      c_c    <= b_c;
      c_lo   <= b_lo;
      c_hi   <= b_hi;
      c_last <= b_last;
      for (int ax = 0; ax < NA; ax++) begin
        c_mlo[ax] <= size_ok && b_wide[ax] &&
                     (b_all || (b_rlo[ax] && near_int(b_plo[ax])));
        c_mhi[ax] <= size_ok && b_wide[ax] &&
                     (b_all || (b_rhi[ax] && near_int(b_phi[ax])));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: move the corners and hold the result for the output side.
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] o_c [NA*NC];
  logic                 o_last;

  always_ff @(posedge clk) begin
    if (rst) o_valid <= 1'b0;
    else if (o_ready) o_valid <= c_valid;
  end

  always_ff @(posedge clk) begin
    int ax;
    if (c_valid && o_ready) begin
      o_last <= c_last;
      for (int k = 0; k < NA * NC; k++) begin
        ax = k / NC;
        if (c_mlo[ax] && (c_c[k] == c_lo[ax])) begin
          o_c[k] <= c_lo[ax] + half_ax[ax];
        end else if (c_mhi[ax] && (c_c[k] == c_hi[ax])) begin
          o_c[k] <= c_hi[ax] - half_ax[ax];
        end else begin
          o_c[k] <= c_c[k];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NA * NC; k++) begin
      m_tdata[k*CW +: CW] = o_c[k];
    end
  end

  assign m_tvalid = o_valid;
  assign m_tlast  = o_last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!stat_u.busy && !stat_v.busy))
    else $error("input accepted while a half-texel step is being computed");

  a_size_write_holds_input: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == quvi_pkg::REG_TEX_WIDTH ||
               cfg_index == quvi_pkg::REG_TEX_HEIGHT) |=> !s_tready)
    else $error("input not held off after a size register write");

  // The step register takes the divider result while done is high, in the cycle after busy drops.
  a_zero_width_zero_step: assert property (@(posedge clk) disable iff (rst)
    (tex_width == '0) && !stat_u.busy && !stat_u.done |-> (half_u == '0))
    else $error("nonzero u step with zero texture width");

endmodule

@@ tb/quad_inset_checker.sv @@
`timescale 1ns / 1ps

// Watches both streams and the register port, predicts every inset quad and
// compares the results in order.
module quad_inset_checker #(
  parameter int UV_FRAC_BITS = 20,
  parameter int TEX_DIM_BITS = 14
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  input  logic                    s_tready,
  input  logic [191:0]            s_tdata,
  input  logic                    s_tuser,
  input  logic                    s_tlast,
  input  logic                    m_tvalid,
  input  logic                    m_tready,
  input  logic [191:0]            m_tdata,
  input  logic                    m_tlast,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [TEX_DIM_BITS-1:0] cfg_data,
  output int                      mismatch_count,
  output int                      quads_in_flight
);

  localparam int COORD_W = quvi_pkg::COORD_W;
  localparam longint ONE_FX = longint'(1) << UV_FRAC_BITS;
  localparam longint SEAM_TOL = (ONE_FX + 50) / 100;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [8*COORD_W-1:0] corners;
    logic                 last;
  } inset_quad_t;

  inset_quad_t expected_quads[$];
  inset_quad_t fresh;
  inset_quad_t oldest;
  longint tex_w, tex_h, half_u, half_v;

  // Half a texel in Q.UV_FRAC_BITS, rounded to nearest with ties up.
  function automatic longint half_texel(input longint size);
    longint h;
    if (size == 0) return 0;
    h = ((longint'(1) << (UV_FRAC_BITS - 1)) + size / 2) / size;
    return (h > longint'(quvi_pkg::HALF_MAX)) ? longint'(quvi_pkg::HALF_MAX) : h;
  endfunction

  // A seam edge sits strictly inside 0..1 and within the tolerance of a
  // texel boundary once scaled by the texture size.
  function automatic bit on_seam(input longint c, input longint size);
    longint prod, frac, distance;
    if (c <= 0 || c >= ONE_FX) return 1'b0;
    prod = c * size;
    frac = prod & (ONE_FX - 1);
    distance = (frac < ONE_FX - frac) ? frac : ONE_FX - frac;
    return distance < SEAM_TOL;
  endfunction

  function automatic logic [4*COORD_W-1:0] inset_axis(input logic [4*COORD_W-1:0] cs,
                                                     input longint size,
                                                     input longint half,
                                                     input bit all);
    longint c[4];
    longint lo, hi;
    bit move_lo, move_hi;
    logic [4*COORD_W-1:0] res;
    for (int i = 0; i < 4; i++) c[i] = longint'($signed(cs[i*COORD_W +: COORD_W]));
    lo = c[0];
    hi = c[0];
    for (int i = 1; i < 4; i++) begin
      if (c[i] < lo) lo = c[i];
      if (c[i] > hi) hi = c[i];
    end
    if (hi - lo > 2 * half) begin
      move_lo = all || on_seam(lo, size);
      move_hi = all || on_seam(hi, size);
      for (int i = 0; i < 4; i++) begin
        if (move_lo && c[i] == lo) c[i] = lo + half;
        else if (move_hi && c[i] == hi) c[i] = hi - half;
      end
    end
    for (int i = 0; i < 4; i++) res[i*COORD_W +: COORD_W] = c[i][COORD_W-1:0];
    return res;
  endfunction

  function automatic logic [8*COORD_W-1:0] predict_inset(input logic [8*COORD_W-1:0] quad,
                                                        input bit all);
    if (tex_w == 0 || tex_h == 0) return quad;
    return {inset_axis(quad[8*COORD_W-1:4*COORD_W], tex_h, half_v, all),
            inset_axis(quad[4*COORD_W-1:0], tex_w, half_u, all)};
  endfunction

  task automatic note_mismatch(input string field, input logic [COORD_W-1:0] want,
                               input logic [COORD_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("mismatch on %s: expected %h, got %h", field, want, got);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tex_w = 0;
      tex_h = 0;
      half_u = 0;
      half_v = 0;
      mismatch_count = 0;
      expected_quads.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          quvi_pkg::REG_TEX_WIDTH: begin
            tex_w = longint'(cfg_data);
            half_u = half_texel(tex_w);
          end
          quvi_pkg::REG_TEX_HEIGHT: begin
            tex_h = longint'(cfg_data);
            half_v = half_texel(tex_h);
          end
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        fresh.corners = predict_inset(s_tdata, s_tuser);
        fresh.last = s_tlast;
        expected_quads.push_back(fresh);
      end
      if (m_tvalid && m_tready) begin
        if (expected_quads.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected quad with nothing pending: %h", m_tdata);
        end else begin
          oldest = expected_quads.pop_front();
          for (int i = 0; i < 8; i++) begin
            if (m_tdata[i*COORD_W +: COORD_W] !== oldest.corners[i*COORD_W +: COORD_W])
              note_mismatch($sformatf("new_%s corner %0d", (i < 4) ? "u" : "v", i % 4),
                            oldest.corners[i*COORD_W +: COORD_W],
                            m_tdata[i*COORD_W +: COORD_W]);
          end
          if (m_tlast !== oldest.last)
            note_mismatch("last_quad_out", COORD_W'(oldest.last), COORD_W'(m_tlast));
        end
      end
    end
    quads_in_flight = expected_quads.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the half-texel quad inset block. The checker beside
// the block predicts every quad; this module only drives items, register
// writes and backpressure, and reports the outcome.
module testbench;

  localparam int UV_FRAC_BITS = 20;
  localparam int TEX_DIM_BITS = 14;
  localparam longint ONE_FX = longint'(1) << UV_FRAC_BITS;
  localparam longint COORD_MIN = -8388608;
  localparam longint COORD_MAX = 8388607;

  // Register indexes that no register answers to.
  localparam logic [1:0] REG_UNMAPPED_A = 2'd2;
  localparam logic [1:0] REG_UNMAPPED_B = 2'd3;

  localparam int QUADS_PER_MODE = 42;
  localparam int SETTINGS_COUNT = 7;
  // The pipeline is four stages deep; give it a few spare cycles.
  localparam int SETTLE_CYCLES = 10;
  // No item moving on either side for this many cycles means the block is stuck. The longest
  // legal quiet stretch is a divider run after a write plus a long stall.
  localparam int STALL_LIMIT = 5000;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // Fields from bit 0 up: u_a, u_b, u_c, u_d, v_a, v_b, v_c, v_d (24 bits each).
  logic [191:0] s_tdata = '0;
  // Fields from bit 0 up: all_edges.
  logic s_tuser = 1'b0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // Fields from bit 0 up: new_u_a .. new_u_d, new_v_a .. new_v_d (24 bits each).
  logic [191:0] m_tdata;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = quvi_pkg::REG_TEX_WIDTH;
  logic [TEX_DIM_BITS-1:0] cfg_data = '0;

  int mismatch_count;
  int quads_in_flight;
  int quiet_cycles = 0;

  // Idle rates in percent for the sender and the receiver.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Sizes currently programmed, used only to steer the random coordinates.
  int cur_w = 0;
  int cur_h = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  quad_uv_half_texel_inset #(
    .UV_FRAC_BITS(UV_FRAC_BITS),
    .TEX_DIM_BITS(TEX_DIM_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  quad_inset_checker #(
    .UV_FRAC_BITS(UV_FRAC_BITS),
    .TEX_DIM_BITS(TEX_DIM_BITS)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatch_count(mismatch_count),
    .quads_in_flight(quads_in_flight)
  );

  // The receiver decides at each falling edge whether to stall the next cycle.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // The watchdog restarts whenever an item moves on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [95:0] pack_axis(input longint c0, input longint c1,
                                            input longint c2, input longint c3);
    return {c3[23:0], c2[23:0], c1[23:0], c0[23:0]};
  endfunction

  // A coordinate at or near a texel boundary of the given size, including the
  // 0 and 1 ends. The jitter straddles the seam tolerance at large sizes.
  function automatic longint seam_coord(input int size);
    longint k;
    if (size == 0) return longint'($urandom_range(0, 1 << UV_FRAC_BITS));
    k = longint'($urandom_range(0, size));
    return (k << UV_FRAC_BITS) / size + longint'($urandom_range(0, 4)) - 2;
  endfunction

  // One axis of a random quad. Most quads are shaped like real sprites, with
  // two corners on the low edge and two on the high edge; the rest is noise,
  // odd shapes and spans right at the skip threshold.
  function automatic logic [95:0] random_axis(input int size);
    longint lo, hi, swap, step;
    longint c[4];
    int kind;
    kind = $urandom_range(0, 9);
    step = (size == 0) ? 1024 : ((longint'(1) << (UV_FRAC_BITS - 1)) + size / 2) / size;
    case (kind)
      0: return {$urandom, $urandom, $urandom};
      1, 2, 3, 4, 5: begin
        lo = seam_coord(size);
        hi = seam_coord(size);
      end
      6: begin
        lo = longint'($urandom_range(0, 3 << UV_FRAC_BITS)) - ONE_FX;
        hi = lo + 2 * step + longint'($urandom_range(0, 2)) - 1;
      end
      7, 8: begin
        lo = longint'($urandom_range(0, 1 << UV_FRAC_BITS));
        hi = longint'($urandom_range(0, 1 << UV_FRAC_BITS));
      end
      default: begin
        lo = longint'($urandom_range(0, 24'hFFFFFF)) + COORD_MIN;
        hi = longint'($urandom_range(0, 24'hFFFFFF)) + COORD_MIN;
      end
    endcase
    if (lo > hi) begin
      swap = lo;
      lo = hi;
      hi = swap;
    end
    if ($urandom_range(0, 1) == 0) c = '{lo, hi, hi, lo};
    else c = '{lo, lo, hi, hi};
    // Now and then one corner sits between the extremes.
    if ($urandom_range(0, 2) == 0)
      c[$urandom_range(0, 3)] = lo + longint'($urandom) % (hi - lo + 1);
    return pack_axis(c[0], c[1], c[2], c[3]);
  endfunction

  // Offers one quad and returns at the falling edge after it was accepted.
  task automatic send_quad(input bit all, input logic [191:0] corners, input bit last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= corners;
    s_tuser <= all;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_quad();
    send_quad($urandom_range(0, 1), {random_axis(cur_h), random_axis(cur_w)},
              $urandom_range(0, 7) == 0);
  endtask

  // Holds the sender back until every quad has come out, then lets the
  // pipeline settle so that a register write lands on an idle block.
  task automatic drain_quads();
    s_tvalid <= 1'b0;
    while (quads_in_flight != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [TEX_DIM_BITS-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == quvi_pkg::REG_TEX_WIDTH) cur_w = int'(value);
    if (idx == quvi_pkg::REG_TEX_HEIGHT) cur_h = int'(value);
  endtask

  task automatic set_texture(input int w, input int h);
    drain_quads();
    write_reg(quvi_pkg::REG_TEX_WIDTH, w[TEX_DIM_BITS-1:0]);
    write_reg(quvi_pkg::REG_TEX_HEIGHT, h[TEX_DIM_BITS-1:0]);
  endtask

  initial begin
    int tex_w_list[SETTINGS_COUNT];
    int tex_h_list[SETTINGS_COUNT];
    int send_list[4];
    int recv_list[4];
    longint seam, half;

    // Texture settings for the random part: the largest size, the smallest,
    // an oversized value with every size bit set, a lopsided pair, a random
    // pair, a zero width that passes quads through, and small odd sizes.
    tex_w_list = '{8192, 1, 16383, 16, 0, 0, 3};
    tex_h_list = '{8192, 1, 16383, 4096, 0, 256, 5};
    tex_w_list[4] = $urandom_range(1, 8192);
    tex_h_list[4] = $urandom_range(1, 8192);
    // Idle modes: none, a mostly idle sender, a mostly stalling receiver, and
    // light idling on both sides.
    send_list = '{0, 85, 0, 10};
    recv_list = '{0, 0, 85, 10};

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part with a size of 16 texels: the half texel is 1/32 and
    // texel boundaries fall every 1/16.
    seam = ONE_FX / 16;
    half = ONE_FX / 32;

    // Straight after reset both sizes are zero, so the quad passes through.
    send_quad(1'b1, {pack_axis(0, 0, ONE_FX, ONE_FX), pack_axis(0, ONE_FX, ONE_FX, 0)}, 1'b0);
    // A zero height alone still passes the whole quad through.
    drain_quads();
    write_reg(quvi_pkg::REG_TEX_WIDTH, 14'd16);
    send_quad(1'b1, {pack_axis(0, 0, ONE_FX, ONE_FX), pack_axis(0, ONE_FX, ONE_FX, 0)}, 1'b1);
    drain_quads();
    write_reg(quvi_pkg::REG_TEX_HEIGHT, 14'd16);

    // A full cell: every edge moves in all-edges mode, but 0 and 1 are not
    // seams, so seam mode leaves it alone.
    send_quad(1'b1, {pack_axis(0, 0, ONE_FX, ONE_FX), pack_axis(0, ONE_FX, ONE_FX, 0)}, 1'b0);
    send_quad(1'b0, {pack_axis(0, 0, ONE_FX, ONE_FX), pack_axis(0, ONE_FX, ONE_FX, 0)}, 1'b0);
    // Exact interior seams move in seam mode.
    send_quad(1'b0, {pack_axis(2*seam, 2*seam, 5*seam, 5*seam),
                     pack_axis(4*seam, 12*seam, 12*seam, 4*seam)}, 1'b0);
    // Just inside the seam tolerance on u, just outside it on v.
    send_quad(1'b0, {pack_axis(4*seam + 656, 4*seam + 656, 12*seam - 656, 12*seam - 656),
                     pack_axis(4*seam + 655, 12*seam - 655, 12*seam - 655, 4*seam + 655)},
              1'b1);
    // A span of exactly two half texels is skipped; one more unit is not.
    send_quad(1'b1, {pack_axis(seam, seam, seam + 2*half + 1, seam + 2*half + 1),
                     pack_axis(seam, seam + 2*half, seam + 2*half, seam)}, 1'b0);
    // The coordinate extremes, in both modes.
    send_quad(1'b1, {pack_axis(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX),
                     pack_axis(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN)}, 1'b0);
    send_quad(1'b0, {pack_axis(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX),
                     pack_axis(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN)}, 1'b1);
    // A degenerate quad with all corners equal.
    send_quad(1'b1, {pack_axis(-5, -5, -5, -5), pack_axis(3*seam, 3*seam, 3*seam, 3*seam)},
              1'b0);
    // Three corners on one extreme.
    send_quad(1'b0, {pack_axis(9*seam, 2*seam, 9*seam, 9*seam),
                     pack_axis(2*seam, 2*seam, 2*seam, 9*seam)}, 1'b0);
    // Negative coordinates never count as seams.
    send_quad(1'b0, {pack_axis(-ONE_FX, -seam, -seam, -ONE_FX),
                     pack_axis(-ONE_FX, -ONE_FX / 2, -ONE_FX / 2, -ONE_FX)}, 1'b0);
    send_quad(1'b1, {pack_axis(-ONE_FX, -seam, -seam, -ONE_FX),
                     pack_axis(-ONE_FX, -ONE_FX / 2, -ONE_FX / 2, -ONE_FX)}, 1'b0);
    // A corner between the extremes stays where it is.
    send_quad(1'b0, {pack_axis(seam, 3*seam, 7*seam, seam),
                     pack_axis(seam, 7*seam, 3*seam, seam)}, 1'b1);
    // Raw noise in every bit.
    repeat (6) begin
      send_quad($urandom_range(0, 1), {$urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom},
                $urandom_range(0, 1));
    end

    // Random part: each texture setting runs under every idle mode.
    for (int s = 0; s < SETTINGS_COUNT; s++) begin
      set_texture(tex_w_list[s], tex_h_list[s]);
      // Writes to unmapped indexes must leave the sizes as they are.
      if (s == 3) begin
        write_reg(REG_UNMAPPED_A, TEX_DIM_BITS'($urandom_range(0, 16383)));
        write_reg(REG_UNMAPPED_B, TEX_DIM_BITS'($urandom_range(0, 16383)));
      end
      for (int m = 0; m < 4; m++) begin
        send_idle_pct = send_list[m];
        recv_stall_pct = recv_list[m];
        repeat (QUADS_PER_MODE) send_random_quad();
      end
    end

    drain_quads();
    if (mismatch_count == 0 && quads_in_flight == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
